/* rtl/blpm_pkg.sv */
// Shared types and constants for the banded peak level meter.
package blpm_pkg;

  // Sample and level widths
  localparam int SAMPLE_W = 16;
  localparam int LEVEL_W  = 16;
  localparam int WEIGHT_W = 16;
  localparam int INDEX_W  = 4;

  // Shared multiplier operand and accumulator widths
  localparam int MUL_W = 17;
  localparam int ACC_W = 33;

  // Q1.16 unity and full-scale level
  localparam logic [MUL_W-1:0]   ONE_Q16   = 17'h10000;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 16'd32768;

  // Register reset values
  localparam logic [WEIGHT_W-1:0] KEEP_RESET  = 16'd39322;
  localparam logic [WEIGHT_W-1:0] DECAY_RESET = 16'd58982;

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_KEEP  = 1'b0;
  localparam logic REG_DECAY = 1'b1;

  // Operation codes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_DECAY  = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PEAK,
    ST_READ,
    ST_MUL0,
    ST_MUL1,
    ST_WRITE
  } state_t;

  // Control of the shared multiply-accumulate unit
  typedef struct packed {
    logic en;
    logic clear;
  } mac_ctl_t;

endpackage

/* rtl/blpm_level_ram.sv */
// Bar level memory with per-entry valid bits that read as zero until written.
module blpm_level_ram import blpm_pkg::*; #(
  parameter int BAR_COUNT = 16,
  parameter int BAR_W     = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               rd,
  input  logic               we,
  input  logic [BAR_W-1:0]   addr,
  input  logic [LEVEL_W-1:0] wdata,
  output logic [LEVEL_W-1:0] rdata
);

  logic [LEVEL_W-1:0] mem [BAR_COUNT];
  logic [BAR_COUNT-1:0] vld;
  logic [LEVEL_W-1:0] rdata_q;
  logic hit_q;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  // Valid bits, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[addr] <= 1'b1;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd) begin
      rdata_q <= mem[addr];
      hit_q   <= vld[addr];
    end
  end

  // An entry never written reads as zero
  assign rdata = hit_q ? rdata_q : '0;

endmodule

/* rtl/blpm_mac.sv */
// Shared 17x17 multiply-accumulate unit.
module blpm_mac import blpm_pkg::*; (
  input  logic             clk,
  input  mac_ctl_t         ctl,
  input  logic [MUL_W-1:0] a,
  input  logic [MUL_W-1:0] b,
  output logic [ACC_W-1:0] acc
);

  logic [2*MUL_W-1:0] prod;

  assign prod = a * b;

  // Accumulate, or restart from the new product
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      acc <= (ctl.clear ? '0 : acc) + ACC_W'(prod);
    end
  end

endmodule

/* rtl/blpm_seq.sv */
// Sequencer: peak tracking, group counting, blend and decay steps, result register.
module blpm_seq import blpm_pkg::*; #(
  parameter int BAR_COUNT       = 16,
  parameter int SAMPLES_PER_BAR = 256,
  parameter int BAR_W           = 4,
  parameter int POS_W           = 9
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 operation,
  input  logic signed [SAMPLE_W-1:0] sample,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [INDEX_W-1:0]   bar_index,
  output logic [LEVEL_W-1:0]   level,
  output logic                 last_bar,
  input  logic [WEIGHT_W-1:0]  keep_weight,
  input  logic [WEIGHT_W-1:0]  decay_factor,
  output logic                 ram_rd,
  output logic                 ram_we,
  output logic [BAR_W-1:0]     ram_addr,
  output logic [LEVEL_W-1:0]   ram_wdata,
  input  logic [LEVEL_W-1:0]   ram_rdata,
  output mac_ctl_t             mac_ctl,
  output logic [MUL_W-1:0]     mac_a,
  output logic [MUL_W-1:0]     mac_b,
  input  logic [ACC_W-1:0]     mac_acc
);

  localparam int IDX_W = (BAR_W > INDEX_W) ? BAR_W : INDEX_W;
  localparam logic [BAR_W-1:0] BAR_LAST = BAR_W'(BAR_COUNT - 1);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(SAMPLES_PER_BAR - 1);

  state_t state, state_next;
  logic op_q, op_q_next;
  logic signed [SAMPLE_W-1:0] sample_q, sample_q_next;
  logic [LEVEL_W-1:0] peak, peak_next;
  logic [POS_W-1:0] pos, pos_next;
  logic [BAR_W-1:0] cur_bar, cur_bar_next;
  logic [BAR_W-1:0] ptr, ptr_next;
  logic out_valid_next;
  logic [BAR_W-1:0] bar_out, bar_out_next;
  logic [LEVEL_W-1:0] level_out, level_out_next;
  logic last_out, last_out_next;

  logic [LEVEL_W-1:0] mag;
  logic [LEVEL_W-1:0] new_level;
  logic [IDX_W-1:0] bar_wide;
  logic group_end;
  logic ptr_last;
  logic out_free;

  // Magnitude of the held sample; the most negative code maps to full scale
  assign mag = sample_q[SAMPLE_W-1] ? (LEVEL_W'(0) - $unsigned(sample_q))
                                    : $unsigned(sample_q);
  assign new_level = mac_acc[LEVEL_W+15:16];
  assign group_end = (pos == POS_LAST);
  assign ptr_last  = (ptr == BAR_LAST);
  assign out_free  = !out_valid || out_ready;

  assign ram_addr  = ptr;
  assign ram_wdata = new_level;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control and data registers
  always_ff @(posedge clk) begin
    if (rst) begin
      peak      <= '0;
      pos       <= '0;
      cur_bar   <= '0;
      out_valid <= 1'b0;
    end else begin
      peak      <= peak_next;
      pos       <= pos_next;
      cur_bar   <= cur_bar_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    op_q      <= op_q_next;
    sample_q  <= sample_q_next;
    ptr       <= ptr_next;
    bar_out   <= bar_out_next;
    level_out <= level_out_next;
    last_out  <= last_out_next;
  end

  // Next state and outputs
  always_comb begin
    state_next     = state;
    op_q_next      = op_q;
    sample_q_next  = sample_q;
    peak_next      = peak;
    pos_next       = pos;
    cur_bar_next   = cur_bar;
    ptr_next       = ptr;
    out_valid_next = out_valid && !out_ready;
    bar_out_next   = bar_out;
    level_out_next = level_out;
    last_out_next  = last_out;
    in_ready       = 1'b0;
    ram_rd         = 1'b0;
    ram_we         = 1'b0;
    mac_ctl        = '0;
    mac_a          = {1'b0, ram_rdata};
    mac_b          = {1'b0, keep_weight};
    case (state)
      ST_IDLE: begin
        // Take the next transaction
        in_ready = 1'b1;
        if (in_valid) begin
          op_q_next     = operation;
          sample_q_next = sample;
          if (operation == OP_DECAY) begin
            ptr_next   = '0;
            state_next = ST_READ;
          end else begin
            state_next = ST_PEAK;
          end
        end
      end
      ST_PEAK: begin
        // Track the peak and advance the group position
        if (mag > peak) begin
          peak_next = mag;
        end
        if (group_end) begin
          ptr_next   = cur_bar;
          state_next = ST_READ;
        end else begin
          pos_next   = pos + POS_W'(1);
          state_next = ST_IDLE;
        end
      end
      ST_READ: begin
        ram_rd     = 1'b1;
        state_next = ST_MUL0;
      end
      ST_MUL0: begin
        // Old level times keep weight or decay factor
        mac_ctl.en    = 1'b1;
        mac_ctl.clear = 1'b1;
        mac_a         = {1'b0, ram_rdata};
        if (op_q == OP_DECAY) begin
          mac_b      = {1'b0, decay_factor};
          state_next = ST_WRITE;
        end else begin
          mac_b      = {1'b0, keep_weight};
          state_next = ST_MUL1;
        end
      end
      ST_MUL1: begin
        // Add peak times the complement of the keep weight
        mac_ctl.en    = 1'b1;
        mac_ctl.clear = 1'b0;
        mac_a         = {1'b0, peak};
        mac_b         = ONE_Q16 - {1'b0, keep_weight};
        state_next    = ST_WRITE;
      end
      ST_WRITE: begin
        // Store the new level and hand it to the result register
        if (out_free) begin
          ram_we         = 1'b1;
          out_valid_next = 1'b1;
          bar_out_next   = ptr;
          level_out_next = new_level;
          last_out_next  = ptr_last;
          if ((op_q == OP_DECAY) && !ptr_last) begin
            ptr_next   = ptr + BAR_W'(1);
            state_next = ST_READ;
          end else begin
            pos_next   = '0;
            peak_next  = '0;
            if (op_q == OP_SAMPLE) begin
              cur_bar_next = (cur_bar == BAR_LAST) ? '0 : cur_bar + BAR_W'(1);
            end
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign bar_wide  = IDX_W'(bar_out);
  assign bar_index = bar_wide[INDEX_W-1:0];
  assign level     = level_out;
  assign last_bar  = last_out;

  // Smoothed levels never pass full scale
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (level <= LEVEL_MAX))
    else $error("level above full scale");

  // The block is busy right after taking a transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken on back-to-back cycles");

  // The current bar stays inside the bar range
  a_bar_range: assert property (@(posedge clk) disable iff (rst)
    cur_bar <= BAR_LAST)
    else $error("current bar out of range");

  // The group position stays inside the group
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos <= POS_LAST)
    else $error("group position out of range");

  // A free result register is loaded from the write step
  a_write_loads: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WRITE && !out_valid) |=> out_valid)
    else $error("result lost in write step");

endmodule

/* rtl/banded_peak_level_meter.sv */
// Top level of the banded peak level meter: register port and unit wiring.
//
// Usage:
//   Input channel (in_valid/in_ready): operation 0 carries a signed 16-bit
//   sample; operation 1 is an idle decay tick. Samples are grouped into runs
//   of SAMPLES_PER_BAR; the end of each run blends its peak into the next bar
//   in turn and emits one result. A decay tick scales all BAR_COUNT levels by
//   decay_factor and emits them in bar order, last_bar set on the final one.
//   Output channel (out_valid/out_ready): bar_index, level, last_bar.
//   Flow: one transaction is in work at a time. A sample inside a run
//   passes the idle and peak steps; a run end then reads, multiplies twice
//   and writes; a decay tick reads, multiplies and writes each bar. The pace
//   is set by the single shared 17x17 MAC unit and the one-port level memory.
//   A stalled receiver holds the sequencer in its write step; no result is
//   dropped. Reset clears all levels (via valid bits, no clearing pass), the
//   peak, the run position and the bar pointer, and loads keep_weight=39322
//   and decay_factor=58982. Registers (APB): keep_weight at 0x0,
//   decay_factor at 0x4; write them only while the block is idle.
module banded_peak_level_meter import blpm_pkg::*; #(
  parameter int BAR_COUNT       = 16,
  parameter int SAMPLES_PER_BAR = 256
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [PADDR_W-1:0]         paddr,
  input  logic [PDATA_W-1:0]         pwdata,
  output logic [PDATA_W-1:0]         prdata,
  output logic                       pready,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       operation,
  input  logic signed [SAMPLE_W-1:0] sample,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [INDEX_W-1:0]         bar_index,
  output logic [LEVEL_W-1:0]         level,
  output logic                       last_bar
);

  localparam int BAR_W = $clog2(BAR_COUNT);
  localparam int POS_W = $clog2(SAMPLES_PER_BAR + 1);

  logic [WEIGHT_W-1:0] keep_weight;
  logic [WEIGHT_W-1:0] decay_factor;
  logic cfg_write;

  logic ram_rd;
  logic ram_we;
  logic [BAR_W-1:0] ram_addr;
  logic [LEVEL_W-1:0] ram_wdata;
  logic [LEVEL_W-1:0] ram_rdata;
  mac_ctl_t mac_ctl;
  logic [MUL_W-1:0] mac_a;
  logic [MUL_W-1:0] mac_b;
  logic [ACC_W-1:0] mac_acc;

  // Register port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      keep_weight  <= KEEP_RESET;
      decay_factor <= DECAY_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == REG_KEEP) begin
        keep_weight <= pwdata[WEIGHT_W-1:0];
      end else begin
        decay_factor <= pwdata[WEIGHT_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_DECAY) ? PDATA_W'(decay_factor)
                                          : PDATA_W'(keep_weight);

  blpm_level_ram #(
    .BAR_COUNT (BAR_COUNT),
    .BAR_W     (BAR_W)
  ) u_ram (
    .clk   (clk),
    .rst   (rst),
    .rd    (ram_rd),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  blpm_mac u_mac (
    .clk (clk),
    .ctl (mac_ctl),
    .a   (mac_a),
    .b   (mac_b),
    .acc (mac_acc)
  );

  blpm_seq #(
    .BAR_COUNT       (BAR_COUNT),
    .SAMPLES_PER_BAR (SAMPLES_PER_BAR),
    .BAR_W           (BAR_W),
    .POS_W           (POS_W)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .sample       (sample),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .bar_index    (bar_index),
    .level        (level),
    .last_bar     (last_bar),
    .keep_weight  (keep_weight),
    .decay_factor (decay_factor),
    .ram_rd       (ram_rd),
    .ram_we       (ram_we),
    .ram_addr     (ram_addr),
    .ram_wdata    (ram_wdata),
    .ram_rdata    (ram_rdata),
    .mac_ctl      (mac_ctl),
    .mac_a        (mac_a),
    .mac_b        (mac_b),
    .mac_acc      (mac_acc)
  );

endmodule
